// ----- rtl/core/orlb_pkg.sv -----
package orlb_pkg;

  localparam int BUFFER_BYTES   = 4096;
  localparam int READ_LIMIT_MAX = 64;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);
  localparam int COUNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int LIMIT_W        = 7;
  localparam int TOTAL_W        = 6;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_WRITE_OK = 2'd0,
    STAT_DATA     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_ERROR    = 2'd3
  } status_t;

  typedef enum logic {
    STATE_IDLE,
    STATE_DRAIN
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [7:0]         write_byte;
    logic [LIMIT_W-1:0] read_limit;
  } in_beat_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         data_byte;
    logic [TOTAL_W-1:0] read_total;
    logic               last;
  } out_beat_t;

endpackage

// ----- rtl/core/overwrite_ring_log_buffer_unit.sv -----
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_ready   in_beat_t  (operation, write_byte, read_limit)
// out_      output     out_valid/out_ready out_beat_t (status, data_byte, read_total, last)
// cfg_      input      cfg_we              cfg_wdata  (logging_enabled)
//
// Writes, errors and empty reads: one beat per cycle while out_ready is high, one result beat each.
// A drain read of n bytes: each byte passes the log memory's read data register, then the result
// register; one byte per cycle while out_ready is high, paced by the single read port of the log memory.
// Synchronous active-low reset clears position, count, enable and handshake state.
// The log memory has no reset and needs no clearing pass: only written bytes are read.
// A stalled out_ready holds the result register; input is taken again once it frees.
module overwrite_ring_log_buffer_unit
  import orlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  logic [7:0]         log_mem [BUFFER_BYTES];
  logic [7:0]         rdata_r;

  state_t             state_r, state_nxt;
  logic               enable_r;
  logic [ADDR_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // drain bookkeeping
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [TOTAL_W-1:0] issue_left_r, issue_left_nxt;
  logic [TOTAL_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               pend_r, pend_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------
  logic               slot_free;   // result register can take a new beat
  logic               accept;
  logic               mem_we;
  logic               rd_en;
  logic               emit;
  logic [LIMIT_W-1:0] lim_sat;
  logic [LIMIT_W-1:0] lim_m1;
  logic [TOTAL_W-1:0] n_read;
  logic [COUNT_W-1:0] pos_ext;
  logic [COUNT_W-1:0] start_full;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == STATE_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mem_we = accept && enable_r && (in_data.operation == OP_WRITE);

  // saturate the limit, then keep one slot back as the reader's terminator
  assign lim_sat = (in_data.read_limit > LIMIT_W'(READ_LIMIT_MAX))
                   ? LIMIT_W'(READ_LIMIT_MAX) : in_data.read_limit;
  assign lim_m1  = lim_sat - LIMIT_W'(1);
  assign n_read  = (count_r < COUNT_W'(lim_m1)) ? count_r[TOTAL_W-1:0]
                                                : lim_m1[TOTAL_W-1:0];

  // oldest byte sits count bytes behind the write position, modulo ring size
  assign pos_ext    = COUNT_W'(wr_pos_r);
  assign start_full = (pos_ext >= count_r) ? pos_ext - count_r
                      : COUNT_W'(BUFFER_BYTES) - (count_r - pos_ext);

  // drain pipeline: the read data register holds a pending byte until it is sent
  assign emit  = (state_r == STATE_DRAIN) && pend_r && slot_free;
  assign rd_en = (state_r == STATE_DRAIN) && (issue_left_r != '0) && (!pend_r || slot_free);

  // ---------------------------------------------------------------------
  // Log memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      log_mem[wr_pos_r] <= in_data.write_byte;
    end
    if (rd_en) begin
      rdata_r <= log_mem[rd_addr_r];
    end
  end

  // ---------------------------------------------------------------------
  // Next state and outputs
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    wr_pos_nxt     = wr_pos_r;
    count_nxt      = count_r;
    rd_addr_nxt    = rd_addr_r;
    issue_left_nxt = issue_left_r;
    emit_idx_nxt   = emit_idx_r;
    total_nxt      = total_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    case (state_r)
      STATE_IDLE: begin
        if (accept) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.data_byte  = '0;
          out_data_nxt.read_total = '0;
          out_data_nxt.last       = 1'b1;
          if (!enable_r) begin
            out_data_nxt.status = STAT_ERROR;
          end else if (in_data.operation == OP_WRITE) begin
            out_data_nxt.status = STAT_WRITE_OK;
            wr_pos_nxt = (wr_pos_r == ADDR_W'(BUFFER_BYTES - 1))
                         ? '0 : wr_pos_r + ADDR_W'(1);
            if (count_r != COUNT_W'(BUFFER_BYTES)) begin
              count_nxt = count_r + COUNT_W'(1);
            end
          end else if (in_data.read_limit == '0) begin
            out_data_nxt.status = STAT_ERROR;
          end else begin
            // the ring empties on every valid read, limit or not
            wr_pos_nxt = '0;
            count_nxt  = '0;
            if (n_read == '0) begin
              out_data_nxt.status = STAT_EMPTY;
            end else begin
              out_valid_nxt  = 1'b0;
              rd_addr_nxt    = start_full[ADDR_W-1:0];
              issue_left_nxt = n_read;
              total_nxt      = n_read;
              emit_idx_nxt   = '0;
              pend_nxt       = 1'b0;
              state_nxt      = STATE_DRAIN;
            end
          end
        end
      end

      STATE_DRAIN: begin
        if (rd_en) begin
          rd_addr_nxt    = (rd_addr_r == ADDR_W'(BUFFER_BYTES - 1))
                           ? '0 : rd_addr_r + ADDR_W'(1);
          issue_left_nxt = issue_left_r - TOTAL_W'(1);
          pend_nxt       = 1'b1;
        end else if (emit) begin
          pend_nxt = 1'b0;
        end
        if (emit) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = STAT_DATA;
          out_data_nxt.data_byte  = rdata_r;
          out_data_nxt.read_total = total_r;
          out_data_nxt.last       = (emit_idx_r + TOTAL_W'(1) == total_r);
          emit_idx_nxt            = emit_idx_r + TOTAL_W'(1);
          if (emit_idx_r + TOTAL_W'(1) == total_r) begin
            state_nxt = STATE_IDLE;
          end
        end
      end

      default: begin
        state_nxt = STATE_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_IDLE;
      enable_r    <= 1'b0;
      wr_pos_r    <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_pos_r    <= wr_pos_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
    end
  end

  // payload and drain counters: no reset needed, qualified by state
  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    issue_left_r <= issue_left_nxt;
    emit_idx_r   <= emit_idx_nxt;
    total_r      <= total_nxt;
    out_data_r   <= out_data_nxt;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == STATE_DRAIN) |-> !in_ready)
    else $error("input taken during drain");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == STATE_DRAIN) |-> (emit_idx_r < total_r))
    else $error("drain emitted past its total");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(BUFFER_BYTES))
    else $error("valid count beyond ring size");

  a_open_beat_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> (out_data_r.status == STAT_DATA))
    else $error("non-final beat that is not data");

  a_drain_empties_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == STATE_DRAIN) |-> (count_r == '0 && wr_pos_r == '0))
    else $error("ring not cleared during drain");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import orlb_pkg::*;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // Block ports; all inputs are known from time zero
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  overwrite_ring_log_buffer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the log ring; starts in its reset state
  logic [7:0]         ring_bytes [BUFFER_BYTES];
  logic [ADDR_W-1:0]  ring_wr_pos     = '0;
  logic [COUNT_W-1:0] ring_fill       = '0;
  logic               logging_on      = 1'b0;

  // Result beats predicted but not yet seen on out_
  out_beat_t pending_results [$];

  // Run bookkeeping
  bit idle_on      = 1'b1;  // random gaps and stalls allowed
  int fault_count  = 0;
  int beats_sent   = 0;
  int beats_seen   = 0;
  int reads_sent   = 0;
  int drained_seen = 0;
  int stall_left   = 0;

  // Push one non-data result (write ok, empty, error): zero payload, last set
  function automatic void push_single(status_t st);
    out_beat_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    pending_results.push_back(r);
  endfunction

  // Work out the result beats of one accepted input beat and advance the ring
  function automatic void predict_log_results(in_beat_t b);
    int unsigned lim;
    int unsigned n;
    int unsigned start;
    out_beat_t   r;
    if (!logging_on) begin
      // disabled block: error, state untouched
      push_single(STAT_ERROR);
    end else if (b.operation == OP_WRITE) begin
      ring_bytes[ring_wr_pos] = b.write_byte;
      ring_wr_pos             = ring_wr_pos + 1'b1;  // wraps at the ring size
      if (ring_fill < BUFFER_BYTES)
        ring_fill = ring_fill + 1'b1;
      push_single(STAT_WRITE_OK);
    end else if (b.read_limit == '0) begin
      // zero limit: error and the ring keeps its contents
      push_single(STAT_ERROR);
    end else begin
      lim = 32'(b.read_limit);
      if (lim > READ_LIMIT_MAX)
        lim = READ_LIMIT_MAX;
      n = (32'(ring_fill) > lim - 1) ? lim - 1 : 32'(ring_fill);
      start = (int'(ring_wr_pos) + BUFFER_BYTES - int'(ring_fill)) % BUFFER_BYTES;
      if (n == 0) begin
        push_single(STAT_EMPTY);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          r            = '0;
          r.status     = STAT_DATA;
          r.data_byte  = ring_bytes[(start + i) % BUFFER_BYTES];
          r.read_total = TOTAL_W'(n);
          r.last       = (i + 1 == n);
          pending_results.push_back(r);
        end
      end
      // any drain read that gets this far empties the whole ring
      ring_wr_pos = '0;
      ring_fill   = '0;
    end
  endfunction

  // Monitor: everything is sampled at the rising edge, before the block's
  // own updates land. Prediction runs ahead of checking in the same block so
  // a same-cycle result can never race its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we)
        logging_on = cfg_wdata;
      if (in_valid && in_ready)
        predict_log_results(in_data);
      if (out_valid && out_ready) begin
        beats_seen++;
        if (out_data.status == STAT_DATA)
          drained_seen++;
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("tb: unexpected result beat %p at %0t", out_data, $realtime);
        end else begin
          automatic out_beat_t want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.data_byte !== want.data_byte ||
              out_data.read_total !== want.read_total || out_data.last !== want.last) begin
            fault_count++;
            if (fault_count <= 10)
              $display("tb: mismatch at %0t: expected %p, got %p", $realtime, want, out_data);
          end
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one input beat and hold it until taken. Valid stays high from the
  // previous beat unless a gap is inserted, so it is never dropped and raised
  // again in one step.
  task automatic send_log_beat(input op_t op, input logic [7:0] byt,
                               input logic [LIMIT_W-1:0] lim);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_data.operation   <= op;
    in_data.write_byte  <= byt;
    in_data.read_limit  <= lim;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (op == OP_READ)
      reads_sent++;
  endtask

  task automatic write_byte_beat(input logic [7:0] byt);
    send_log_beat(OP_WRITE, byt, LIMIT_W'($urandom));
  endtask

  task automatic read_beat(input logic [LIMIT_W-1:0] lim);
    send_log_beat(OP_READ, 8'($urandom), lim);
  endtask

  // Drop valid and let every expected result drain out
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only ever with the block quiet
  task automatic set_logging(input logic en);
    settle_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random drain limit: mostly in range, some zero, one, and at or above the cap
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return LIMIT_W'(1);
      2:       return LIMIT_W'($urandom_range(READ_LIMIT_MAX, 127));
      default: return LIMIT_W'($urandom_range(2, READ_LIMIT_MAX));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Out of reset logging is off: both operations are refused
  task automatic test_disabled_block();
    write_byte_beat(8'h5A);
    read_beat(LIMIT_W'(READ_LIMIT_MAX));
  endtask

  // Short hand-picked cases with logging on
  task automatic test_directed_drains();
    set_logging(1'b1);
    read_beat(LIMIT_W'(10));           // empty ring
    write_byte_beat(8'h00);
    write_byte_beat(8'hFF);
    write_byte_beat(8'hA5);
    read_beat('0);                     // zero limit: error, ring kept
    read_beat(LIMIT_W'(1));            // no room for a byte: empty, ring cleared
    read_beat(LIMIT_W'(READ_LIMIT_MAX)); // must now be empty
    for (int i = 0; i < 5; i++)
      write_byte_beat(8'(8'h10 + i));
    read_beat(LIMIT_W'(3));            // two oldest, the rest dropped
    read_beat(LIMIT_W'(10));           // nothing left
    write_byte_beat(8'h3C);
    write_byte_beat(8'hC3);
    write_byte_beat(8'h81);
    read_beat(LIMIT_W'(127));          // limit saturates at the cap
  endtask

  // Fill past the read cap, then drain a full-length read: only the oldest
  // bytes fit, the rest go when the ring clears
  task automatic test_long_fill();
    for (int i = 0; i < READ_LIMIT_MAX + 2; i++)
      write_byte_beat(8'($urandom));
    read_beat(LIMIT_W'(READ_LIMIT_MAX));
    read_beat(LIMIT_W'(READ_LIMIT_MAX));
  endtask

  // Mostly write bursts closed by a drain read, with some loose noise beats
  task automatic run_traffic(input int budget);
    int start;
    int burst;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 70)
                                             : $urandom_range(0, 20);
        repeat (burst) write_byte_beat(8'($urandom));
        read_beat(pick_limit());
      end else begin
        send_log_beat(op_t'($urandom_range(0, 1)), 8'($urandom), LIMIT_W'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(120);
    // short spell with logging off mid-run, then back on
    set_logging(1'b0);
    run_traffic(15);
    set_logging(1'b1);
    run_traffic(95);
  endtask

  // Last stretch runs flat out: no gaps, no stalls
  task automatic test_flat_out();
    settle_idle();
    idle_on = 1'b0;
    run_traffic(70);
  endtask

  initial begin
    int wait_cycles;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_disabled_block();
    test_directed_drains();
    test_long_fill();
    test_random_traffic();
    test_flat_out();

    // Drain what is left, with a bound on the wait
    @(negedge clk);
    in_valid    <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 50000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0) begin
      fault_count++;
      $display("tb: %0d expected result beats never arrived", pending_results.size());
    end

    $display("tb: %0d input beats (%0d drain reads), %0d result beats checked",
             beats_sent, reads_sent, beats_seen);
    $display("tb: %0d drained bytes, drains past the read cap exercised, %0d faults",
             drained_seen, fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/orlb_pkg.sv
rtl/core/overwrite_ring_log_buffer_unit.sv
bench/testbench.sv
